// ===== rtl/core/uer_pkg.sv =====
`timescale 1ns / 1ps

package uer_pkg;

    localparam int DIST_W    = 14;
    localparam int TICK16_W  = 16;
    localparam int TIMEOUT_W = 19;
    localparam int SCALE_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 19;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SETTLE  = 3'd1,
        PH_PULSE   = 3'd2,
        PH_WAIT    = 3'd3,
        PH_MEASURE = 3'd4
    } phase_t;

    typedef struct packed {
        logic start_req;
        logic sensor_side;
        logic echo_left;
        logic echo_right;
    } tick_in_t;

    typedef struct packed {
        logic              trig_left;
        logic              trig_right;
        logic              busy_res;
        logic              done_res;
        logic [DIST_W-1:0] distance_cm;
    } tick_out_t;

endpackage

// ===== rtl/core/uer_scale.sv =====
`timescale 1ns / 1ps

module uer_scale #(
    parameter int COUNT_WIDTH = 19,
    parameter int SCALE_SHIFT = 20
) (
    input  logic [COUNT_WIDTH-1:0]       count,
    input  logic [uer_pkg::SCALE_W-1:0]  scale_mult,
    output logic [uer_pkg::DIST_W-1:0]   distance
);
    import uer_pkg::*;

    localparam int PROD_W = COUNT_WIDTH + SCALE_W;
    localparam int PW_A   = PROD_W + 1;
    localparam int PW_B   = SCALE_SHIFT + DIST_W + 1;
    localparam int PW     = (PW_A > PW_B) ? PW_A : PW_B;

    logic [PROD_W-1:0] prod;
    logic [PW-1:0]     rounded;
    logic [PW-1:0]     shifted;

    // Round half up, then saturate to the distance field.
    always_comb begin
        prod     = PROD_W'(count) * PROD_W'(scale_mult);
        rounded  = PW'(prod) + (PW'(1) << (SCALE_SHIFT - 1));
        shifted  = rounded >> SCALE_SHIFT;
        if (shifted > PW'(DIST_MAX)) begin
            distance = DIST_MAX;
        end else begin
            distance = shifted[DIST_W-1:0];
        end
    end

endmodule

// ===== rtl/core/ultrasonic_echo_ranger_top.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  tick_in_t: start_req, sensor_side, echo lines
// m_        out        m_valid / m_ready  tick_out_t: triggers, busy, done, distance
// cfg_      in         cfg_we only        cfg_index selects register, cfg_data value
//
// Every input transaction is one timebase tick and yields exactly one result in the next
// cycle; a new tick is taken every cycle unless the result stalls. The sequencer, its
// counters and the distance multiply all sit between the state and result registers.
// Reset is synchronous and active low; it restores the register defaults and idles the
// sequencer. A stalled result holds in the result register, and input is refused only
// while that register is full and not being drained.

module ultrasonic_echo_ranger_top #(
    parameter int COUNT_WIDTH = 19,
    parameter int SCALE_SHIFT = 20
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  uer_pkg::tick_in_t             s_data,

    output logic                          m_valid,
    input  logic                          m_ready,
    output uer_pkg::tick_out_t            m_data,

    input  logic                          cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data
);
    import uer_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // Configuration registers.
    logic [TICK16_W-1:0]  settle_reg;
    logic [TICK16_W-1:0]  pulse_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [SCALE_W-1:0]   scale_reg;

    // Sequencer state.
    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] phase_count_reg, phase_count_next;
    logic [COUNT_WIDTH-1:0] echo_count_reg, echo_count_next;
    logic                   side_reg, side_next;
    logic [DIST_W-1:0]      dist_reg, dist_next;
    logic                   done_next;

    // Result register.
    logic      m_valid_reg;
    tick_out_t m_data_reg;

    logic                   accept;
    logic                   echo;
    logic [COUNT_WIDTH-1:0] scale_count;
    logic [DIST_W-1:0]      scaled;

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
        bump = (c == CNT_MAX) ? c : c + COUNT_WIDTH'(1);
    endfunction

    // A limit is reached at or beyond the limit itself or when the counter is full.
    function automatic logic reached(input logic [COUNT_WIDTH-1:0] c,
                                     input logic [CMP_W-1:0] limit);
        reached = (CMP_W'(c) >= limit) || (c == CNT_MAX);
    endfunction

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The sensor chosen at start decides which echo line is watched.
    assign echo = side_reg ? s_data.echo_right : s_data.echo_left;

    // The echo count a measurement can end on this tick: one on the rising tick,
    // otherwise the running count, advanced while the echo is still high.
    assign scale_count = (phase_reg == PH_MEASURE) ?
                         (echo ? bump(echo_count_reg) : echo_count_reg) :
                         COUNT_WIDTH'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg  <= TICK16_W'(10);
            pulse_reg   <= TICK16_W'(10);
            timeout_reg <= TIMEOUT_W'(500000);
            scale_reg   <= SCALE_W'(17983);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SETTLE:  settle_reg  <= cfg_data[TICK16_W-1:0];
                REG_PULSE:   pulse_reg   <= cfg_data[TICK16_W-1:0];
                REG_TIMEOUT: timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                REG_SCALE:   scale_reg   <= cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    uer_scale #(
        .COUNT_WIDTH(COUNT_WIDTH),
        .SCALE_SHIFT(SCALE_SHIFT)
    ) u_scale (
        .count      (scale_count),
        .scale_mult (scale_reg),
        .distance   (scaled)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            phase_count_reg <= '0;
            echo_count_reg  <= '0;
            side_reg        <= 1'b0;
            dist_reg        <= '0;
        end else if (accept) begin
            phase_reg       <= phase_next;
            phase_count_reg <= phase_count_next;
            echo_count_reg  <= echo_count_next;
            side_reg        <= side_next;
            dist_reg        <= dist_next;
        end
    end

    // Next state for one tick. The scaler sees the echo count this tick leaves
    // whenever a measurement ends on it.
    always_comb begin
        phase_next       = phase_reg;
        phase_count_next = phase_count_reg;
        echo_count_next  = echo_count_reg;
        side_next        = side_reg;
        dist_next        = dist_reg;
        done_next        = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                if (s_data.start_req) begin
                    side_next        = s_data.sensor_side;
                    phase_next       = PH_SETTLE;
                    phase_count_next = '0;
                end
            end
            PH_SETTLE: begin
                phase_count_next = bump(phase_count_reg);
                if (reached(phase_count_next, CMP_W'(settle_reg))) begin
                    phase_next       = PH_PULSE;
                    phase_count_next = '0;
                end
            end
            PH_PULSE: begin
                phase_count_next = bump(phase_count_reg);
                if (reached(phase_count_next, CMP_W'(pulse_reg))) begin
                    phase_next       = PH_WAIT;
                    phase_count_next = '0;
                end
            end
            PH_WAIT: begin
                if (echo) begin
                    // The rising tick already counts as one high sample.
                    echo_count_next  = COUNT_WIDTH'(1);
                    phase_count_next = '0;
                    phase_next       = PH_MEASURE;
                    if (reached(echo_count_next, CMP_W'(timeout_reg))) begin
                        dist_next  = scaled;
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                end else begin
                    phase_count_next = bump(phase_count_reg);
                    if (reached(phase_count_next, CMP_W'(timeout_reg))) begin
                        // No echo arrived: report zero distance.
                        echo_count_next = '0;
                        dist_next       = '0;
                        phase_next      = PH_IDLE;
                        done_next       = 1'b1;
                    end
                end
            end
            PH_MEASURE: begin
                if (echo) begin
                    echo_count_next = bump(echo_count_reg);
                    if (reached(echo_count_next, CMP_W'(timeout_reg))) begin
                        dist_next  = scaled;
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                end else begin
                    dist_next  = scaled;
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // The result shows the state after the tick that produced it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg.trig_left   <= (phase_next == PH_PULSE) && !side_next;
            m_data_reg.trig_right  <= (phase_next == PH_PULSE) && side_next;
            m_data_reg.busy_res    <= (phase_next != PH_IDLE);
            m_data_reg.done_res    <= done_next;
            m_data_reg.distance_cm <= dist_next;
        end
    end

endmodule
